// ===== hw/rtl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the MIDI track event parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] StatusSysex = 8'hF0;
  localparam logic [3:0] HiProgram   = 4'hC;
  localparam logic [3:0] HiPressure  = 4'hD;

  typedef enum logic [3:0] {
    PH_DELTA   = 4'd0,
    PH_STATUS  = 4'd1,
    PH_DATA1   = 4'd2,
    PH_DATA2   = 4'd3,
    PH_TYPE    = 4'd4,
    PH_LENGTH  = 4'd5,
    PH_PAYLOAD = 4'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_CHANNEL = 3'd0,
    KIND_SYSEX   = 3'd1,
    KIND_META    = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_TRUNC   = 3'd4
  } kind_t;

  // Compact result record carried from front to back.
  // byte_a: first data byte or payload byte; byte_b: second data byte.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] delta;
    logic [7:0]  status;
    logic [7:0]  meta;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [1:0]  cnt;
    logic [31:0] len;
    logic        last;
  } rec_t;

  function automatic phase_t after_status(input logic [7:0] s);
    phase_t p;
    if (s < StatusSysex) begin
      p = PH_DATA1;
    end else if (s == StatusSysex) begin
      p = PH_LENGTH;
    end else begin
      p = PH_TYPE;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtep_front.sv =====
// ----------------------------------------------------------------------------
// mtep_front
// Byte parser: tracks phase, running status and accumulators, and emits at
// most one result record per accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          track_start,
  input  wire logic          track_end,
  output mtep_pkg::rec_t     rec,
  output logic               rec_valid
);

  mtep_pkg::phase_t phase, phase_next;
  logic [7:0]  running_status, running_status_next;
  logic [31:0] delta_acc, delta_acc_next;
  logic [31:0] len_acc, len_acc_next;
  logic [31:0] remain, remain_next;
  logic [7:0]  held_meta, held_meta_next;
  logic [7:0]  held_first, held_first_next;
  logic        finished, finished_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtep_pkg::PH_DELTA;
      running_status <= '0;
      delta_acc      <= '0;
      len_acc        <= '0;
      remain         <= '0;
      held_meta      <= '0;
      held_first     <= '0;
      finished       <= 1'b0;
    end else if (take) begin
      phase          <= phase_next;
      running_status <= running_status_next;
      delta_acc      <= delta_acc_next;
      len_acc        <= len_acc_next;
      remain         <= remain_next;
      held_meta      <= held_meta_next;
      held_first     <= held_first_next;
      finished       <= finished_next;
    end
  end

  always_comb begin
    logic run;
    logic complete;
    logic trunc_now;
    phase_next          = phase;
    running_status_next = running_status;
    delta_acc_next      = delta_acc;
    len_acc_next        = len_acc;
    remain_next         = remain;
    held_meta_next      = held_meta;
    held_first_next     = held_first;
    finished_next       = finished;
    rec                 = '0;
    rec_valid           = 1'b0;
    run                 = 1'b0;
    complete            = 1'b0;
    trunc_now           = 1'b0;

    if (track_start) begin
      phase_next          = mtep_pkg::PH_DELTA;
      running_status_next = '0;
      delta_acc_next      = '0;
      len_acc_next        = '0;
      remain_next         = '0;
      held_meta_next      = '0;
      held_first_next     = '0;
      finished_next       = 1'b0;
    end

    if (!finished_next) begin
      if (phase_next == mtep_pkg::PH_STATUS) begin
        if (data_byte[7]) begin
          running_status_next = data_byte;
          held_meta_next = '0;
          if (data_byte == mtep_pkg::StatusSysex) begin
            len_acc_next = '0;
          end
          phase_next = mtep_pkg::after_status(data_byte);
        end else if (!running_status_next[7]) begin
          // data before any status
          trunc_now = 1'b1;
        end else begin
          // running status: this byte is the first one after the status
          held_meta_next = '0;
          if (running_status_next == mtep_pkg::StatusSysex) begin
            len_acc_next = '0;
          end
          phase_next = mtep_pkg::after_status(running_status_next);
          run = 1'b1;
        end
      end else begin
        run = 1'b1;
      end

      if (run) begin
        case (phase_next)
          mtep_pkg::PH_DATA1: begin
            if (running_status_next[7:4] == mtep_pkg::HiProgram ||
                running_status_next[7:4] == mtep_pkg::HiPressure) begin
              rec.kind   = mtep_pkg::KIND_CHANNEL;
              rec.byte_a = data_byte;
              rec.cnt    = 2'd1;
              rec_valid  = 1'b1;
              complete   = 1'b1;
            end else begin
              held_first_next = data_byte;
              phase_next      = mtep_pkg::PH_DATA2;
            end
          end
          mtep_pkg::PH_DATA2: begin
            rec.kind   = mtep_pkg::KIND_CHANNEL;
            rec.byte_a = held_first_next;
            rec.byte_b = data_byte;
            rec.cnt    = 2'd2;
            rec_valid  = 1'b1;
            complete   = 1'b1;
          end
          mtep_pkg::PH_TYPE: begin
            held_meta_next = data_byte;
            len_acc_next   = '0;
            phase_next     = mtep_pkg::PH_LENGTH;
          end
          mtep_pkg::PH_LENGTH: begin
            len_acc_next = {len_acc_next[24:0], data_byte[6:0]};
            if (!data_byte[7]) begin
              rec.kind  = (running_status_next == mtep_pkg::StatusSysex) ?
                          mtep_pkg::KIND_SYSEX : mtep_pkg::KIND_META;
              rec.meta  = held_meta_next;
              rec.len   = len_acc_next;
              rec_valid = 1'b1;
              remain_next = len_acc_next;
              if (len_acc_next == '0) begin
                complete = 1'b1;
              end else begin
                phase_next = mtep_pkg::PH_PAYLOAD;
              end
            end
          end
          mtep_pkg::PH_PAYLOAD: begin
            remain_next = remain_next - 32'd1;
            rec.kind    = mtep_pkg::KIND_PAYLOAD;
            rec.meta    = held_meta_next;
            rec.len     = len_acc_next;
            rec.byte_a  = data_byte;
            rec.last    = (remain_next == '0);
            rec_valid   = 1'b1;
            complete    = (remain_next == '0);
          end
          default: begin
            delta_acc_next = {delta_acc_next[24:0], data_byte[6:0]};
            phase_next = data_byte[7] ? mtep_pkg::PH_DELTA : mtep_pkg::PH_STATUS;
          end
        endcase
      end

      rec.delta  = delta_acc_next;
      rec.status = running_status_next;

      if (complete) begin
        phase_next     = mtep_pkg::PH_DELTA;
        delta_acc_next = '0;
      end

      // early end replaces whatever this byte produced
      if (trunc_now || (track_end && !complete)) begin
        rec        = '0;
        rec.kind   = mtep_pkg::KIND_TRUNC;
        rec.delta  = delta_acc_next;
        rec.status = running_status_next;
        rec_valid  = 1'b1;
      end
      if (trunc_now || track_end) begin
        finished_next = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtep_fifo.sv =====
// ----------------------------------------------------------------------------
// mtep_fifo
// Short record queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire mtep_pkg::rec_t wr_rec,
  input  wire logic           rd_en,
  output mtep_pkg::rec_t      rd_rec,
  output logic                rd_valid,
  output logic                is_full
);

  mtep_pkg::rec_t entries [mtep_pkg::FifoDepth];
  logic [mtep_pkg::FifoPtrW-1:0] wr_ptr, rd_ptr;
  logic [mtep_pkg::FifoCntW-1:0] count;
  logic do_wr, do_rd;

  assign is_full  = (count == mtep_pkg::FifoCntW'(mtep_pkg::FifoDepth));
  assign rd_valid = (count != '0);
  assign rd_rec   = entries[rd_ptr];
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + mtep_pkg::FifoPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + mtep_pkg::FifoPtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + mtep_pkg::FifoCntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - mtep_pkg::FifoCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtep_back.sv =====
// ----------------------------------------------------------------------------
// mtep_back
// Output stage: holds the oldest result and expands it into result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module mtep_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mtep_pkg::rec_t head_rec,
  input  wire logic           head_valid,
  output logic                head_take,
  input  wire logic           pop,
  output logic                empty,
  output logic [2:0]          result_kind,
  output logic [31:0]         delta_ticks,
  output logic [7:0]          status_byte,
  output logic [7:0]          meta_type,
  output logic [7:0]          first_data,
  output logic [7:0]          second_data,
  output logic [1:0]          data_count,
  output logic [31:0]         payload_length,
  output logic [7:0]          payload_value,
  output logic                payload_last
);

  mtep_pkg::rec_t held;
  logic           held_valid;
  logic           is_chan, is_pay, is_hdr;

  assign empty     = !held_valid;
  assign head_take = head_valid && (!held_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (head_take) begin
      held_valid <= 1'b1;
    end else if (pop) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (head_take) begin
      held <= head_rec;
    end
  end

  assign is_chan = (held.kind == mtep_pkg::KIND_CHANNEL);
  assign is_pay  = (held.kind == mtep_pkg::KIND_PAYLOAD);
  assign is_hdr  = (held.kind == mtep_pkg::KIND_SYSEX) ||
                   (held.kind == mtep_pkg::KIND_META) || is_pay;

  assign result_kind    = held.kind;
  assign delta_ticks    = held.delta;
  assign status_byte    = held.status;
  assign meta_type      = is_hdr ? held.meta : 8'd0;
  assign first_data     = is_chan ? held.byte_a : 8'd0;
  assign second_data    = is_chan ? held.byte_b : 8'd0;
  assign data_count     = is_chan ? held.cnt : 2'd0;
  assign payload_length = is_hdr ? held.len : 32'd0;
  assign payload_value  = is_pay ? held.byte_a : 8'd0;
  assign payload_last   = is_pay && held.last;

endmodule

`default_nettype wire

// ===== hw/rtl/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses Standard MIDI File track bytes into channel events, sysex/meta
// headers, payload bytes and truncation marks.
//
//   Channel  Direction  Handshake      Payload
//   input    in         push / full    data_byte, track_start, track_end
//   result   out        empty / pop    result_kind .. payload_last
//
// One byte is taken per cycle while full is low; each yields zero or one result.
// The parser state updates in the cycle a byte is taken; its result enters a
// 4-entry queue and then the output register on its way to the result ports.
// full rises only when the queue is full, i.e. after the result side has
// stalled for several results. Synchronous reset empties queue and output.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_track_event_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        track_start,
  input  wire logic        track_end,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       result_kind,
  output logic [31:0]      delta_ticks,
  output logic [7:0]       status_byte,
  output logic [7:0]       meta_type,
  output logic [7:0]       first_data,
  output logic [7:0]       second_data,
  output logic [1:0]       data_count,
  output logic [31:0]      payload_length,
  output logic [7:0]       payload_value,
  output logic             payload_last
);

  logic           take;
  mtep_pkg::rec_t new_rec;
  logic           new_valid;
  mtep_pkg::rec_t head_rec;
  logic           head_valid;
  logic           head_take;

  assign take = push && !full;

  mtep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (data_byte),
    .track_start (track_start),
    .track_end   (track_end),
    .rec         (new_rec),
    .rec_valid   (new_valid)
  );

  mtep_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take && new_valid),
    .wr_rec   (new_rec),
    .rd_en    (head_take),
    .rd_rec   (head_rec),
    .rd_valid (head_valid),
    .is_full  (full)
  );

  mtep_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_rec       (head_rec),
    .head_valid     (head_valid),
    .head_take      (head_take),
    .pop            (pop),
    .empty          (empty),
    .result_kind    (result_kind),
    .delta_ticks    (delta_ticks),
    .status_byte    (status_byte),
    .meta_type      (meta_type),
    .first_data     (first_data),
    .second_data    (second_data),
    .data_count     (data_count),
    .payload_length (payload_length),
    .payload_value  (payload_value),
    .payload_last   (payload_last)
  );

endmodule

`default_nettype wire
